// ----- hdl/l2h_pkg.sv -----
// lookup2 hash package: accumulator and pipeline-word types, constants, one mix round
// no dependencies; imported by l2h_mix and lookup2_key_hash_bucket
`default_nettype none

package l2h_pkg;

   localparam logic [31:0] GOLDEN_INIT       = 32'h9e3779b9;
   localparam int          MIX_STAGES        = 9;
   localparam logic [3:0]  WORD_B_POS        = 4'd4;
   localparam logic [3:0]  WORD_C_POS        = 4'd8;
   localparam logic [3:0]  BLOCK_LAST        = 4'd11;
   localparam int          BUCKET_W          = 24;
   localparam logic [4:0]  BUCKET_BITS_RESET = 5'd10;
   localparam int          CSR_ADDR_W        = 3;
   localparam logic        REG_BUCKET_BITS   = 1'b0;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } abc_type;

   // one word moving through a mix pipeline
   typedef struct packed {
      logic        valid;
      logic        key_end;
      logic        mixed;
      logic        has_block;
      logic [31:0] len;
   } job_type;

   typedef enum logic [1:0] {
      ROLE_A,
      ROLE_B,
      ROLE_C
   } role_type;

   localparam abc_type INIT_ABC = '{a: GOLDEN_INIT, b: GOLDEN_INIT, c: 32'h0};

   localparam role_type MIX_ROLE [MIX_STAGES] = '{
      ROLE_A, ROLE_B, ROLE_C, ROLE_A, ROLE_B, ROLE_C, ROLE_A, ROLE_B, ROLE_C
   };

   localparam logic [4:0] MIX_SHIFT [MIX_STAGES] = '{
      5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
   };

   // one of the nine rounds of the lookup2 mix
   function automatic abc_type mix_step(input abc_type v, input logic [3:0] k);
      abc_type    r;
      logic [4:0] amt;
      r   = v;
      amt = MIX_SHIFT[k];
      case (MIX_ROLE[k])
         ROLE_A: r.a = (v.a - v.b - v.c) ^ (v.c >> amt);
         ROLE_B: r.b = (v.b - v.c - v.a) ^ (v.a << amt);
         ROLE_C: r.c = (v.c - v.a - v.b) ^ (v.b >> amt);
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lookup2_key_hash_bucket.sv -----
// lookup2_key_hash_bucket: streaming lookup2 hash of byte keys with a bucket index
// top level; depends on l2h_pkg and l2h_mix
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | key_byte, byte_present, key_end
//   rsp      | out       | rsp_valid/rsp_stall  | hash_word, bucket_index
//   csr      | in/out    | apb, pready always 1 | bucket_bits at byte address 0
//
// one byte accepted per cycle while req_stall is low; a key's result passes through
// two nine-stage mix pipelines (block mix, then final mix) plus two registers
// a completed block is mixed while the next block's bytes are collected
// reset clears key state and pipeline valids; bucket_bits returns to 10
// a stalled result moves into a skid register; req_stall rises only when that is full
`default_nettype none

module lookup2_key_hash_bucket import l2h_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_key_byte,
   input  wire logic                  req_byte_present,
   input  wire logic                  req_key_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [31:0]                rsp_hash_word,
   output logic [BUCKET_W-1:0]        rsp_bucket_index,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // configuration
   logic [4:0] bucket_bits_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_BUCKET_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_bits_ff <= BUCKET_BITS_RESET;
      end else if (csr_write) begin
         bucket_bits_ff <= csr_pwdata[4:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_BUCKET_BITS) ? {27'b0, bucket_bits_ff} : 32'b0;

   // handshake
   logic advance;
   logic accept;
   logic skid_valid_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   // block collection
   logic [31:0] w0_ff, w1_ff, w0_in, w1_in;
   logic [23:0] third_ff, third_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic        has_block_ff, has_block_in;

   logic [31:0] nw0, nw1, nlen;
   logic [23:0] nthird;
   logic [3:0]  npos;
   logic [4:0]  lane_lsb;
   logic        blk;
   abc_type     base_ff, base_sel;
   abc_type     entry_abc;
   job_type     entry_job;

   always_comb begin
      nw0      = w0_ff;
      nw1      = w1_ff;
      nthird   = third_ff;
      nlen     = len_ff;
      npos     = pos_ff;
      blk      = 1'b0;
      lane_lsb = {1'b0, pos_ff[1:0], 2'b00} << 1;
      if (req_byte_present) begin
         nlen = len_ff + 32'd1;
         npos = pos_ff + 4'd1;
         if (pos_ff < WORD_B_POS) begin
            nw0[lane_lsb +: 8] = req_key_byte;
         end else if (pos_ff < WORD_C_POS) begin
            nw1[lane_lsb +: 8] = req_key_byte;
         end else if (pos_ff < BLOCK_LAST) begin
            nthird[lane_lsb +: 8] = req_key_byte;
         end else begin
            blk = 1'b1;
         end
      end
   end

   assign base_sel = has_block_ff ? base_ff : INIT_ABC;

   always_comb begin
      entry_job.valid     = accept && (blk || req_key_end);
      entry_job.key_end   = req_key_end;
      entry_job.len       = nlen;
      if (blk) begin
         // full block: chain value plus the block's words, mixed in the first pipeline
         entry_job.mixed     = 1'b1;
         entry_job.has_block = 1'b1;
         entry_abc.a = base_sel.a + w0_ff;
         entry_abc.b = base_sel.b + w1_ff;
         entry_abc.c = base_sel.c + {req_key_byte, third_ff};
      end else begin
         // key end inside a block: carry the tail addends, chain value added later
         entry_job.mixed     = 1'b0;
         entry_job.has_block = has_block_ff;
         entry_abc.a = nw0;
         entry_abc.b = nw1;
         entry_abc.c = {nthird, 8'h00} + nlen;
      end
   end

   always_comb begin
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      third_in     = third_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      has_block_in = has_block_ff;
      if (accept) begin
         if (req_key_end) begin
            w0_in        = 32'b0;
            w1_in        = 32'b0;
            third_in     = 24'b0;
            pos_in       = 4'd0;
            len_in       = 32'b0;
            has_block_in = 1'b0;
         end else if (blk) begin
            w0_in        = 32'b0;
            w1_in        = 32'b0;
            third_in     = 24'b0;
            pos_in       = 4'd0;
            len_in       = nlen;
            has_block_in = 1'b1;
         end else begin
            w0_in    = nw0;
            w1_in    = nw1;
            third_in = nthird;
            pos_in   = npos;
            len_in   = nlen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff        <= 32'b0;
         w1_ff        <= 32'b0;
         third_ff     <= 24'b0;
         pos_ff       <= 4'd0;
         len_ff       <= 32'b0;
         has_block_ff <= 1'b0;
      end else begin
         w0_ff        <= w0_in;
         w1_ff        <= w1_in;
         third_ff     <= third_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         has_block_ff <= has_block_in;
      end
   end

   // block mix pipeline
   abc_type blk_abc;
   job_type blk_job;

   l2h_mix u_block_mix (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_abc  (entry_abc),
      .in_job  (entry_job),
      .out_abc (blk_abc),
      .out_job (blk_job)
   );

   // chain value for the next block of the same key
   always_ff @(posedge clock) begin
      if (advance && blk_job.valid && blk_job.mixed) begin
         base_ff <= blk_abc;
      end
   end

   // final addition
   abc_type fin_src, fin_add, fin_abc_in, fin_abc_ff;
   logic    fin_valid_in, fin_valid_ff;

   always_comb begin
      if (blk_job.mixed) begin
         fin_src = blk_abc;
         fin_add = '{a: 32'h0, b: 32'h0, c: blk_job.len};
      end else begin
         fin_src = blk_job.has_block ? base_ff : INIT_ABC;
         fin_add = blk_abc;
      end
      fin_abc_in.a = fin_src.a + fin_add.a;
      fin_abc_in.b = fin_src.b + fin_add.b;
      fin_abc_in.c = fin_src.c + fin_add.c;
      fin_valid_in = blk_job.valid && blk_job.key_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_abc_ff <= fin_abc_in;
      end
   end

   // final mix pipeline
   job_type fin_job;
   abc_type hash_abc;
   job_type hash_job;

   assign fin_job = '{valid: fin_valid_ff, key_end: 1'b1, mixed: 1'b1,
                      has_block: 1'b0, len: 32'h0};

   l2h_mix u_final_mix (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_abc  (fin_abc_ff),
      .in_job  (fin_job),
      .out_abc (hash_abc),
      .out_job (hash_job)
   );

   // bucket mask, saturating at the index width
   logic [BUCKET_W-1:0] bucket_mask;
   logic [BUCKET_W-1:0] bucket_in;

   always_comb begin
      for (int i = 0; i < BUCKET_W; i++) begin
         bucket_mask[i] = (5'(i) < bucket_bits_ff);
      end
      bucket_in = hash_abc.c[BUCKET_W-1:0] & bucket_mask;
   end

   // output register and skid register
   logic                out_valid_ff;
   logic [31:0]         out_hash_ff, skid_hash_ff;
   logic [BUCKET_W-1:0] out_bucket_ff, skid_bucket_ff;
   logic                out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= hash_job.valid;
      end else if (hash_job.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_hash_ff   <= skid_hash_ff;
            out_bucket_ff <= skid_bucket_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_hash_ff   <= hash_abc.c;
         out_bucket_ff <= bucket_in;
      end else begin
         skid_hash_ff   <= hash_abc.c;
         skid_bucket_ff <= bucket_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hash_word    = out_hash_ff;
   assign rsp_bucket_index = out_bucket_ff;

`ifndef SYNTH
   // a key end leaves the collection state clean for the next key
   a_key_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_key_end) |=> (pos_ff == 4'd0 && len_ff == 32'd0 && !has_block_ff))
      else $error("key state not cleared after key end");

   // the twelfth byte closes the block and marks the key as chained
   a_block_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_byte_present && !req_key_end && pos_ff == BLOCK_LAST)
      |=> (pos_ff == 4'd0 && has_block_ff && third_ff == 24'b0))
      else $error("block did not close at its last byte");

   // third-word bytes only exist once the first two words are full
   a_third_clean: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= WORD_C_POS) |-> (third_ff == 24'b0))
      else $error("stale third-word bytes");
`endif

endmodule

`default_nettype wire

// ----- hdl/l2h_mix.sv -----
// l2h_mix: the lookup2 mix as a nine-stage pipeline, one round per stage
// a word with mixed low passes through unchanged; depends on l2h_pkg
`default_nettype none

module l2h_mix import l2h_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire abc_type in_abc,
   input  wire job_type in_job,
   output abc_type      out_abc,
   output job_type      out_job
);

   abc_type stage_src   [MIX_STAGES];
   abc_type stage_abc_in[MIX_STAGES];
   abc_type stage_abc_ff[MIX_STAGES];
   job_type stage_job_in[MIX_STAGES];
   job_type stage_job_ff[MIX_STAGES];

   genvar g;
   for (g = 0; g < MIX_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_head
         assign stage_src[g]    = in_abc;
         assign stage_job_in[g] = in_job;
      end else begin : g_body
         assign stage_src[g]    = stage_abc_ff[g-1];
         assign stage_job_in[g] = stage_job_ff[g-1];
      end

      assign stage_abc_in[g] = stage_job_in[g].mixed ? mix_step(stage_src[g], 4'(g))
                                                     : stage_src[g];

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_job_ff[g].valid <= 1'b0;
         end else if (advance) begin
            stage_job_ff[g] <= stage_job_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_abc_ff[g] <= stage_abc_in[g];
         end
      end
   end

   assign out_abc = stage_abc_ff[MIX_STAGES-1];
   assign out_job = stage_job_ff[MIX_STAGES-1];

endmodule

`default_nettype wire
